/* design/rfd_pkg.sv */
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared constants for the relative fractional delay block: default sizes
// of the sample ring and sample fields, and the width of the delay register.
// ----------------------------------------------------------------------------
package rfd_pkg;

    // Default ring depth and sample formats
    localparam int DEPTH_DEF      = 64;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int FREQ_WIDTH_DEF = 24;
    localparam int ENV_WIDTH_DEF  = 16;

    // Delay register width (signed, fraction bits set by FRAC_BITS)
    localparam int CFG_WIDTH      = 15;

endpackage

/* design/rfd_interp.sv */
// ----------------------------------------------------------------------------
// rfd_interp
// Linear interpolation between a near and a far sample:
// near + floor((far - near) * frac / 2^FRAC_BITS), for signed or unsigned data.
// ----------------------------------------------------------------------------
module rfd_interp
    import rfd_pkg::*;
#(
    parameter int WIDTH     = FREQ_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter bit IS_SIGNED = 1'b1
)
(
    input  logic [WIDTH-1:0]     near,
    input  logic [WIDTH-1:0]     far,
    input  logic [FRAC_BITS-1:0] frac,
    output logic [WIDTH-1:0]     value
);

    logic signed [WIDTH:0]             near_x;
    logic signed [WIDTH:0]             far_x;
    logic signed [WIDTH:0]             diff;
    logic signed [WIDTH+FRAC_BITS+1:0] prod;
    logic signed [WIDTH+FRAC_BITS+1:0] step;
    logic signed [WIDTH:0]             sum;

    // Extend both samples by one bit so the difference cannot overflow
    always_comb
    begin
        if (IS_SIGNED)
        begin
            near_x = $signed({near[WIDTH-1], near});
            far_x  = $signed({far[WIDTH-1], far});
        end
        else
        begin
            near_x = $signed({1'b0, near});
            far_x  = $signed({1'b0, far});
        end
    end

    // Scale the difference; arithmetic shift gives the floor
    always_comb
    begin
        diff  = far_x - near_x;
        prod  = diff * $signed({1'b0, frac});
        step  = prod >>> FRAC_BITS;
        sum   = near_x + step[WIDTH:0];
        value = sum[WIDTH-1:0];
    end

endmodule

/* design/relative_fractional_delay_top.sv */
// Path: an accepted item goes through the memory read, then the result register.
// Throughput: one item per cycle unless stalled; set by the two-port read of the shared sample ring.
// Stalls: a stalled result holds in the output register while the next item waits in the read stage.
// Reset: clears write index, fill count, last-sample registers and delay; ring entries not
//   written since reset read as zero through the fill count, so no clearing pass is needed.
// Config: the delay is clamped when written; write it only while the block is idle.
// ----------------------------------------------------------------------------
// relative_fractional_delay_top
// Relative fractional delay between a frequency deviation stream and an
// envelope stream, both read back from one shared sample ring by linear
// interpolation. A positive delay holds frequency back, a negative one the
// envelope.
// ----------------------------------------------------------------------------
module relative_fractional_delay_top
    import rfd_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int FREQ_WIDTH = FREQ_WIDTH_DEF,
    parameter int ENV_WIDTH  = ENV_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Input item channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [FREQ_WIDTH-1:0] freq_dev_sample,
    input  logic [ENV_WIDTH-1:0]  envelope_sample,

    // Result item channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [FREQ_WIDTH-1:0] delayed_freq_dev,
    output logic [ENV_WIDTH-1:0]  delayed_envelope,
    output logic [ENV_WIDTH-1:0]  envelope_at_freq_lag,
    output logic [ENV_WIDTH-1:0]  envelope_min_at_freq_lag,
    output logic [FREQ_WIDTH-1:0] raw_freq_near,
    output logic [FREQ_WIDTH-1:0] raw_freq_far,

    // Delay register write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_WIDTH-1:0]  relative_delay_q8
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = FREQ_WIDTH + ENV_WIDTH;
    localparam int LIMIT  = (DEPTH - 2) * (2 ** FRAC_BITS);

    // ------------------------------------------------------------------------
    // Delay register, clamped and split into sign, whole and fraction
    // ------------------------------------------------------------------------
    logic                 lag_neg_reg;
    logic [ADDR_W-1:0]    lag_whole_reg;
    logic [FRAC_BITS-1:0] lag_frac_reg;
    logic signed [31:0]   delay_ext;
    logic signed [31:0]   delay_abs;
    logic signed [31:0]   delay_clamp;
    logic                 cfg_write;

    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        delay_ext = $signed({{(32-CFG_WIDTH){relative_delay_q8[CFG_WIDTH-1]}},
                             relative_delay_q8});
        delay_abs = (delay_ext < 0) ? -delay_ext : delay_ext;
        if (delay_abs > LIMIT)
            delay_clamp = LIMIT;
        else
            delay_clamp = delay_abs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_neg_reg   <= 1'b0;
            lag_whole_reg <= '0;
            lag_frac_reg  <= '0;
        end
        else if (cfg_write)
        begin
            lag_neg_reg   <= (delay_ext < 0);
            lag_whole_reg <= delay_clamp[FRAC_BITS +: ADDR_W];
            lag_frac_reg  <= delay_clamp[FRAC_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Handshake: read stage and result register
    // ------------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_en;
    logic accept;

    assign out_en    = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !out_en;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign cfg_ready = !s1_valid_reg && !out_valid_reg;

    assign s1_valid_next = accept || (s1_valid_reg && !out_en);

    // ------------------------------------------------------------------------
    // Write index, fill count and ring addresses
    // ------------------------------------------------------------------------
    logic [ADDR_W-1:0] wr_idx_reg;
    logic [ADDR_W-1:0] wr_idx_next;
    logic [ADDR_W-1:0] fill_reg;
    logic [ADDR_W-1:0] fill_next;
    logic [ADDR_W:0]   near_wrap;
    logic [ADDR_W-1:0] near_addr;
    logic [ADDR_W-1:0] far_addr;
    logic              near_ok;
    logic              far_ok;

    always_comb
    begin
        wr_idx_next = (wr_idx_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
        fill_next   = (fill_reg == ADDR_W'(DEPTH - 1)) ? fill_reg : fill_reg + 1'b1;

        // Step back by the whole lag, modulo DEPTH
        near_wrap = {1'b0, wr_idx_reg} + (ADDR_W+1)'(DEPTH) - {1'b0, lag_whole_reg};
        if (wr_idx_reg >= lag_whole_reg)
            near_addr = wr_idx_reg - lag_whole_reg;
        else
            near_addr = near_wrap[ADDR_W-1:0];
        far_addr = (near_addr == '0) ? ADDR_W'(DEPTH - 1) : near_addr - 1'b1;

        // An entry counts only if it was written since reset
        near_ok = (fill_reg >= lag_whole_reg);
        far_ok  = ({1'b0, fill_reg} >= ({1'b0, lag_whole_reg} + 1'b1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            fill_reg   <= '0;
        end
        else if (accept)
        begin
            wr_idx_reg <= wr_idx_next;
            fill_reg   <= fill_next;
        end
    end

    // ------------------------------------------------------------------------
    // Shared sample ring: one write, two registered reads per cycle
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0] ring_mem [DEPTH];
    logic [WORD_W-1:0] near_q_reg;
    logic [WORD_W-1:0] far_q_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[wr_idx_reg] <= {freq_dev_sample, envelope_sample};
            near_q_reg           <= ring_mem[near_addr];
            far_q_reg            <= ring_mem[far_addr];
        end
    end

    // ------------------------------------------------------------------------
    // Read stage: current sample, last sample and entry flags
    // ------------------------------------------------------------------------
    logic [FREQ_WIDTH-1:0] s1_freq_cur_reg;
    logic [ENV_WIDTH-1:0]  s1_env_cur_reg;
    logic [FREQ_WIDTH-1:0] s1_freq_prev_reg;
    logic [ENV_WIDTH-1:0]  s1_env_prev_reg;
    logic                  s1_near_ok_reg;
    logic                  s1_far_ok_reg;
    logic [FREQ_WIDTH-1:0] last_freq_reg;
    logic [ENV_WIDTH-1:0]  last_env_reg;

    // Track the entry just behind the write index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_freq_reg <= '0;
            last_env_reg  <= '0;
        end
        else if (accept)
        begin
            last_freq_reg <= freq_dev_sample;
            last_env_reg  <= envelope_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_freq_cur_reg  <= freq_dev_sample;
            s1_env_cur_reg   <= envelope_sample;
            s1_freq_prev_reg <= last_freq_reg;
            s1_env_prev_reg  <= last_env_reg;
            s1_near_ok_reg   <= near_ok;
            s1_far_ok_reg    <= far_ok;
        end
    end

    // ------------------------------------------------------------------------
    // Select near and far samples at each lag
    // ------------------------------------------------------------------------
    logic [FREQ_WIDTH-1:0] lagl_freq_near;
    logic [FREQ_WIDTH-1:0] lagl_freq_far;
    logic [ENV_WIDTH-1:0]  lagl_env_near;
    logic [ENV_WIDTH-1:0]  lagl_env_far;
    logic [FREQ_WIDTH-1:0] fl_freq_near;
    logic [FREQ_WIDTH-1:0] fl_freq_far;
    logic [ENV_WIDTH-1:0]  fl_env_near;
    logic [ENV_WIDTH-1:0]  fl_env_far;
    logic [ENV_WIDTH-1:0]  el_env_near;
    logic [ENV_WIDTH-1:0]  el_env_far;
    logic [FRAC_BITS-1:0]  fl_frac;
    logic [FRAC_BITS-1:0]  el_frac;
    logic [ENV_WIDTH-1:0]  env_min;

    always_comb
    begin
        // Entries at the full lag; zero lag reads the item itself
        if (lag_whole_reg == '0)
        begin
            lagl_freq_near = s1_freq_cur_reg;
            lagl_env_near  = s1_env_cur_reg;
        end
        else if (s1_near_ok_reg)
        begin
            lagl_freq_near = near_q_reg[WORD_W-1 -: FREQ_WIDTH];
            lagl_env_near  = near_q_reg[ENV_WIDTH-1:0];
        end
        else
        begin
            lagl_freq_near = '0;
            lagl_env_near  = '0;
        end

        if (s1_far_ok_reg)
        begin
            lagl_freq_far = far_q_reg[WORD_W-1 -: FREQ_WIDTH];
            lagl_env_far  = far_q_reg[ENV_WIDTH-1:0];
        end
        else
        begin
            lagl_freq_far = '0;
            lagl_env_far  = '0;
        end

        // Negative delay: frequency side sits at lag zero
        if (lag_neg_reg)
        begin
            fl_freq_near = s1_freq_cur_reg;
            fl_freq_far  = s1_freq_prev_reg;
            fl_env_near  = s1_env_cur_reg;
            fl_env_far   = s1_env_prev_reg;
            el_env_near  = lagl_env_near;
            el_env_far   = lagl_env_far;
            fl_frac      = '0;
            el_frac      = lag_frac_reg;
        end
        else
        begin
            fl_freq_near = lagl_freq_near;
            fl_freq_far  = lagl_freq_far;
            fl_env_near  = lagl_env_near;
            fl_env_far   = lagl_env_far;
            el_env_near  = s1_env_cur_reg;
            el_env_far   = s1_env_prev_reg;
            fl_frac      = lag_frac_reg;
            el_frac      = '0;
        end

        env_min = (fl_env_near < fl_env_far) ? fl_env_near : fl_env_far;
    end

    // ------------------------------------------------------------------------
    // Interpolators
    // ------------------------------------------------------------------------
    logic [FREQ_WIDTH-1:0] freq_interp;
    logic [ENV_WIDTH-1:0]  env_interp;
    logic [ENV_WIDTH-1:0]  env_fl_interp;

    rfd_interp #(
        .WIDTH     (FREQ_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .IS_SIGNED (1'b1)
    ) u_freq_interp (
        .near  (fl_freq_near),
        .far   (fl_freq_far),
        .frac  (fl_frac),
        .value (freq_interp)
    );

    rfd_interp #(
        .WIDTH     (ENV_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .IS_SIGNED (1'b0)
    ) u_env_interp (
        .near  (el_env_near),
        .far   (el_env_far),
        .frac  (el_frac),
        .value (env_interp)
    );

    rfd_interp #(
        .WIDTH     (ENV_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .IS_SIGNED (1'b0)
    ) u_env_fl_interp (
        .near  (fl_env_near),
        .far   (fl_env_far),
        .frac  (fl_frac),
        .value (env_fl_interp)
    );

    // ------------------------------------------------------------------------
    // Result register: advance when empty or taken, hold while stalled
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s1_valid_reg)
        begin
            delayed_freq_dev         <= freq_interp;
            delayed_envelope         <= env_interp;
            envelope_at_freq_lag     <= env_fl_interp;
            envelope_min_at_freq_lag <= env_min;
            raw_freq_near            <= fl_freq_near;
            raw_freq_far             <= fl_freq_far;
        end
    end

`ifndef SYNTHESIS
    // An accepted item always occupies the read stage next cycle
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted item lost before read stage");

    // Write index advances by one, modulo DEPTH, per accepted item
    a_wr_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=>
            (wr_idx_reg == (($past(wr_idx_reg) == ADDR_W'(DEPTH - 1)) ?
                            '0 : $past(wr_idx_reg) + 1'b1)))
        else $error("write index did not advance correctly");

    // Clamped whole lag never reaches the entry being written
    a_lag_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        lag_whole_reg <= ADDR_W'(DEPTH - 2))
        else $error("whole lag beyond clamp limit");

    // Interpolated envelope lies at or above the smaller raw entry
    a_env_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (envelope_min_at_freq_lag <= envelope_at_freq_lag))
        else $error("interpolated envelope below raw minimum");
`endif

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the relative fractional delay block. Items carry
// a frequency and an envelope sample; a scoreboard keeps its own copy of
// both rings and of the delay register, predicts the six result fields of
// every accepted item and checks each result against the oldest prediction.
// Both channels idle and stall at random; the delay is changed between
// phases only while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rfd_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int FRAC_BITS      = FRAC_BITS_DEF;
    localparam int FREQ_WIDTH     = FREQ_WIDTH_DEF;
    localparam int ENV_WIDTH      = ENV_WIDTH_DEF;
    localparam int DELAY_LIMIT    = (DEPTH - 2) << FRAC_BITS;
    localparam int FRAC_MASK      = (1 << FRAC_BITS) - 1;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 152;

    typedef struct packed {
        logic [FREQ_WIDTH-1:0] delayed_freq_dev;
        logic [ENV_WIDTH-1:0]  delayed_envelope;
        logic [ENV_WIDTH-1:0]  envelope_at_freq_lag;
        logic [ENV_WIDTH-1:0]  envelope_min_at_freq_lag;
        logic [FREQ_WIDTH-1:0] raw_freq_near;
        logic [FREQ_WIDTH-1:0] raw_freq_far;
    } delay_result_t;

    // Predict results from a private copy of both rings and the delay
    class delay_scoreboard;
        longint        freq_hist [DEPTH];
        longint        env_hist [DEPTH];
        int            wr_ptr;
        int            delay_q8;
        delay_result_t expected_q [$];
        int            errors;

        function new();
            for (int i = 0; i < DEPTH; i++)
            begin
                freq_hist[i] = 0;
                env_hist[i]  = 0;
            end
            wr_ptr   = 0;
            delay_q8 = 0;
            errors   = 0;
        endfunction

        function void set_delay(logic [CFG_WIDTH-1:0] value);
            delay_q8 = int'($signed(value));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int hist_pos(int whole, int extra);
            return (wr_ptr + 2 * DEPTH - whole - extra) % DEPTH;
        endfunction

        // near + floor((far - near) * frac / 2^FRAC_BITS)
        function longint lerp(longint near, longint far, int frac);
            longint prod;
            prod = (far - near) * longint'(frac);
            return near + (prod >>> FRAC_BITS);
        endfunction

        function void note_input(logic [FREQ_WIDTH-1:0] freq, logic [ENV_WIDTH-1:0] env);
            int            d;
            int            freq_lag;
            int            env_lag;
            int            fw;
            int            ff;
            int            ew;
            int            ef;
            longint        en_near;
            longint        en_far;
            delay_result_t r;
            freq_hist[wr_ptr] = longint'($signed(freq));
            env_hist[wr_ptr]  = longint'(env);

            // Clamp the delay and split it into the two lags
            d = delay_q8;
            if (d > DELAY_LIMIT)
                d = DELAY_LIMIT;
            if (d < -DELAY_LIMIT)
                d = -DELAY_LIMIT;
            freq_lag = (d > 0) ? d : 0;
            env_lag  = (d < 0) ? -d : 0;
            fw = freq_lag >> FRAC_BITS;
            ff = freq_lag & FRAC_MASK;
            ew = env_lag >> FRAC_BITS;
            ef = env_lag & FRAC_MASK;

            en_near = env_hist[hist_pos(fw, 0)];
            en_far  = env_hist[hist_pos(fw, 1)];

            r.delayed_freq_dev = FREQ_WIDTH'(lerp(freq_hist[hist_pos(fw, 0)],
                                                  freq_hist[hist_pos(fw, 1)], ff));
            r.delayed_envelope = ENV_WIDTH'(lerp(env_hist[hist_pos(ew, 0)],
                                                 env_hist[hist_pos(ew, 1)], ef));
            r.envelope_at_freq_lag     = ENV_WIDTH'(lerp(en_near, en_far, ff));
            r.envelope_min_at_freq_lag = ENV_WIDTH'((en_near < en_far) ? en_near : en_far);
            r.raw_freq_near = FREQ_WIDTH'(freq_hist[hist_pos(fw, 0)]);
            r.raw_freq_far  = FREQ_WIDTH'(freq_hist[hist_pos(fw, 1)]);
            expected_q.push_back(r);

            wr_ptr = (wr_ptr + 1) % DEPTH;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(delay_result_t got);
            delay_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result item with no input item pending");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("delayed_freq_dev", 32'(want.delayed_freq_dev),
                          32'(got.delayed_freq_dev));
            compare_field("delayed_envelope", 32'(want.delayed_envelope),
                          32'(got.delayed_envelope));
            compare_field("envelope_at_freq_lag", 32'(want.envelope_at_freq_lag),
                          32'(got.envelope_at_freq_lag));
            compare_field("envelope_min_at_freq_lag", 32'(want.envelope_min_at_freq_lag),
                          32'(got.envelope_min_at_freq_lag));
            compare_field("raw_freq_near", 32'(want.raw_freq_near), 32'(got.raw_freq_near));
            compare_field("raw_freq_far", 32'(want.raw_freq_far), 32'(got.raw_freq_far));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [FREQ_WIDTH-1:0] freq_dev_sample;
    logic [ENV_WIDTH-1:0]  envelope_sample;
    logic                  out_valid;
    logic                  out_stall;
    logic [FREQ_WIDTH-1:0] delayed_freq_dev;
    logic [ENV_WIDTH-1:0]  delayed_envelope;
    logic [ENV_WIDTH-1:0]  envelope_at_freq_lag;
    logic [ENV_WIDTH-1:0]  envelope_min_at_freq_lag;
    logic [FREQ_WIDTH-1:0] raw_freq_near;
    logic [FREQ_WIDTH-1:0] raw_freq_far;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_WIDTH-1:0]  relative_delay_q8;

    delay_scoreboard sb;
    int              gap_max;
    int              stall_max;
    bit              hold_off_req;
    int              idle_cycles;

    relative_fractional_delay_top DUT (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .in_valid                 (in_valid),
        .in_stall                 (in_stall),
        .freq_dev_sample          (freq_dev_sample),
        .envelope_sample          (envelope_sample),
        .out_valid                (out_valid),
        .out_stall                (out_stall),
        .delayed_freq_dev         (delayed_freq_dev),
        .delayed_envelope         (delayed_envelope),
        .envelope_at_freq_lag     (envelope_at_freq_lag),
        .envelope_min_at_freq_lag (envelope_min_at_freq_lag),
        .raw_freq_near            (raw_freq_near),
        .raw_freq_far             (raw_freq_far),
        .cfg_valid                (cfg_valid),
        .cfg_ready                (cfg_ready),
        .relative_delay_q8        (relative_delay_q8)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Check results, note accepted items, and end the run if nothing moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result({delayed_freq_dev, delayed_envelope, envelope_at_freq_lag,
                                 envelope_min_at_freq_lag, raw_freq_near, raw_freq_far});
            if (in_valid && !in_stall)
                sb.note_input(freq_dev_sample, envelope_sample);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    // Stall the result channel per item; take a long hold-off when asked
    initial
    begin : result_sink
        int hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            else
                hold = $urandom_range(stall_max, 0);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Offer one item after a gap and hold it until accepted
    task automatic send_item(input logic [FREQ_WIDTH-1:0] freq,
                             input logic [ENV_WIDTH-1:0] env, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        freq_dev_sample <= freq;
        envelope_sample <= env;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop the input and wait until every predicted result has come
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the delay register once the block is idle
    task automatic write_delay(input logic [CFG_WIDTH-1:0] value);
        wait_drained();
        cfg_valid         <= 1'b1;
        relative_delay_q8 <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_delay(value);
    endtask

    // Reset, directed items, then random phases
    initial
    begin : stimulus
        logic [FREQ_WIDTH-1:0] f;
        logic [ENV_WIDTH-1:0]  e;
        logic [CFG_WIDTH-1:0]  d;
        sb                = new();
        gap_max           = 0;
        stall_max         = 0;
        hold_off_req      = 1'b0;
        idle_cycles       = 0;
        rst_n             <= 1'b0;
        in_valid          <= 1'b0;
        freq_dev_sample   <= '0;
        envelope_sample   <= '0;
        cfg_valid         <= 1'b0;
        relative_delay_q8 <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero delay from reset: each near read returns the item itself
        send_item(24'h7FFFFF, 16'hFFFF, 0);
        send_item(24'h800000, 16'h0000, 0);
        send_item(24'h000000, 16'h8000, 0);
        send_item(24'h7FFFFF, 16'h0000, 0);

        // Positive delay past the limit: saturates, reads unwritten entries as zero
        write_delay(15'h3FFF);
        send_item(24'h800000, 16'hFFFF, 0);
        send_item(24'h7FFFFF, 16'h0001, 0);
        send_item(24'h000001, 16'hFFFE, 0);
        send_item(24'hFFFFFF, 16'h0000, 0);
        send_item(24'h555555, 16'hAAAA, 0);
        send_item(24'hAAAAAA, 16'h5555, 0);

        // Negative delay past the limit: envelope held back, saturated
        write_delay(15'h4000);
        send_item(24'h7FFFFF, 16'hFFFF, 0);
        send_item(24'h800000, 16'h0000, 0);
        send_item(24'h123456, 16'hFFFF, 0);
        send_item(24'h800000, 16'h0000, 1);
        send_item(24'h7FFFFF, 16'hFFFF, 2);
        send_item(24'h000000, 16'h0000, 0);

        // Fractional positive lag between opposite extremes
        write_delay(15'h0180);
        send_item(24'h7FFFFF, 16'hFFFF, 0);
        send_item(24'h800000, 16'h0000, 0);
        send_item(24'h7FFFFF, 16'hFFFF, 0);
        send_item(24'h800000, 16'h0000, 0);
        send_item(24'h7FFFFF, 16'h0000, 0);

        // Fractional negative lag
        write_delay(-15'sd128);
        send_item(24'h800000, 16'hFFFF, 0);
        send_item(24'h7FFFFF, 16'h0000, 0);
        send_item(24'h800000, 16'hFFFF, 0);
        send_item(24'h000000, 16'h0001, 0);

        // Random phases, each with its own delay and idling pattern
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    gap_max   = 19;
                    stall_max = 19;
                end
                1:
                begin
                    gap_max   = 0;
                    stall_max = 0;
                end
                2:
                begin
                    gap_max   = 0;
                    stall_max = 19;
                end
                default:
                begin
                    gap_max   = 19;
                    stall_max = 0;
                end
            endcase
            case (p)
                0:       d = 15'(DELAY_LIMIT);
                1:       d = 15'(-DELAY_LIMIT);
                2:       d = 15'd1;
                3:       d = -15'sd1;
                4:       d = 15'd255;
                5:       d = -15'sd256;
                default: d = 15'($urandom_range(32767, 0));
            endcase
            write_delay(d);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Hold the results off while items keep coming, so the block fills
                if (p == 2 && k == 20)
                    hold_off_req = 1'b1;
                case ($urandom_range(7, 0))
                    0:       f = 24'h7FFFFF;
                    1:       f = 24'h800000;
                    2:       f = 24'h000000;
                    default: f = FREQ_WIDTH'($urandom);
                endcase
                case ($urandom_range(7, 0))
                    0:       e = 16'hFFFF;
                    1:       e = 16'h0000;
                    default: e = ENV_WIDTH'($urandom);
                endcase
                send_item(f, e, $urandom_range(gap_max, 0));
            end
        end

        wait_drained();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
